// ----- hdl/tgc_pkg.sv -----
// Shared widths, constants and sideband type for the triangle tangent pipeline.
// No dependencies.
package tgc_pkg;

    localparam int IDX_W  = 16;
    localparam int POS_W  = 16;
    localparam int DIF_W  = 17;
    localparam int PROD_W = 34;
    localparam int T_W    = 35;
    localparam int MAG_W  = 35;
    localparam int TOP_W  = 6;
    localparam int NRM_W  = 24;
    localparam int SQ_W   = 48;
    localparam int SUM_W  = 50;
    localparam int ROOT_W = 25;
    localparam int REM_W  = 28;
    localparam int QUO_W  = 15;
    localparam int NUM_W  = 39;
    localparam int OUT_W  = 16;
    localparam int FRONT_STAGES = 8;

    localparam logic [TOP_W-1:0] NRM_TOP = TOP_W'(23);
    localparam logic [QUO_W-1:0] Q_ONE   = QUO_W'(16384);

    typedef logic [2:0][NRM_W-1:0] nrm3_t;

    typedef struct packed {
        logic [IDX_W-1:0] idx_a;
        logic [IDX_W-1:0] idx_b;
        logic [IDX_W-1:0] idx_c;
        logic             hand_neg;
        logic             degen;
        logic [2:0]       neg;
    } side_t;

endpackage

// ----- hdl/tgc_front.sv -----
// Front pipeline: edge differences, products, raw tangent, magnitudes,
// normalizing shift and sum of squares. Depends on tgc_pkg.
module tgc_front
    import tgc_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              en,
    input  logic              in_valid,
    input  logic [IDX_W-1:0]  idx_a,
    input  logic [IDX_W-1:0]  idx_b,
    input  logic [IDX_W-1:0]  idx_c,
    input  logic [47:0]       pos0,
    input  logic [47:0]       pos1,
    input  logic [47:0]       pos2,
    input  logic [31:0]       uv0,
    input  logic [31:0]       uv1,
    input  logic [31:0]       uv2,
    output logic              out_valid,
    output side_t             out_side,
    output nrm3_t             out_mag,
    output logic [SUM_W-1:0]  out_sum
);

    function automatic logic signed [DIF_W-1:0] sub16(logic [POS_W-1:0] a,
                                                      logic [POS_W-1:0] b);
        return {a[POS_W-1], a} - {b[POS_W-1], b};
    endfunction

    logic [FRONT_STAGES-1:0] vld_reg;
    side_t sd_reg [FRONT_STAGES];

    logic signed [DIF_W-1:0]  e1_reg [3];
    logic signed [DIF_W-1:0]  e2_reg [3];
    logic signed [DIF_W-1:0]  du1_reg, dv1_reg, du2_reg, dv2_reg;
    logic signed [PROD_W-1:0] pa_reg [3];
    logic signed [PROD_W-1:0] pb_reg [3];
    logic signed [PROD_W-1:0] pd1_reg, pd2_reg;
    logic signed [T_W-1:0]    t_reg [3];
    logic                     det_neg_reg, det_zero_reg;
    logic [MAG_W-1:0]         mag_reg [3];
    logic [MAG_W-1:0]         max_reg;
    logic [MAG_W-1:0]         mag5_reg [3];
    logic [TOP_W-1:0]         top_reg;
    nrm3_t                    nrm_reg;
    logic [SQ_W-1:0]          sq_reg [3];
    nrm3_t                    nrm7_reg;
    nrm3_t                    nrm8_reg;
    logic [SUM_W-1:0]         sum_reg;

    logic signed [T_W-1:0] det_next;
    logic [MAG_W-1:0]      abs_next [3];
    logic [MAG_W-1:0]      max_next;
    logic [TOP_W-1:0]      top_next;
    logic                  tz_next;
    side_t                 sd1_next;
    side_t                 sd2_next;
    side_t                 sd3_next;

    assign det_next = T_W'(pd1_reg) - T_W'(pd2_reg);

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            abs_next[k] = t_reg[k][T_W-1] ? MAG_W'(-t_reg[k]) : MAG_W'(t_reg[k]);
        end
        max_next = abs_next[0];
        if (abs_next[1] > max_next) max_next = abs_next[1];
        if (abs_next[2] > max_next) max_next = abs_next[2];
        tz_next = (t_reg[0] == '0) && (t_reg[1] == '0) && (t_reg[2] == '0);

        sd1_next          = sd_reg[0];
        sd1_next.idx_a    = idx_a;
        sd1_next.idx_b    = idx_b;
        sd1_next.idx_c    = idx_c;
        sd1_next.hand_neg = 1'b0;
        sd1_next.degen    = 1'b0;
        sd1_next.neg      = '0;

        sd2_next          = sd_reg[1];
        sd2_next.hand_neg = !det_next[T_W-1] && (det_next != '0);

        sd3_next          = sd_reg[2];
        sd3_next.degen    = det_zero_reg || tz_next;
        for (int k = 0; k < 3; k++) begin
            sd3_next.neg[k] = t_reg[k][T_W-1] ^ det_neg_reg;
        end
    end

    always_comb begin
        top_next = '0;
        for (int i = 0; i < MAG_W; i++) begin
            if (max_reg[i]) top_next = TOP_W'(i);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (en) begin
            vld_reg <= {vld_reg[FRONT_STAGES-2:0], in_valid};
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            // stage 1: differences
            sd_reg[0] <= sd1_next;
            for (int k = 0; k < 3; k++) begin
                e1_reg[k] <= sub16(pos1[16*k +: 16], pos0[16*k +: 16]);
                e2_reg[k] <= sub16(pos2[16*k +: 16], pos0[16*k +: 16]);
            end
            du1_reg <= sub16(uv1[15:0],  uv0[15:0]);
            dv1_reg <= sub16(uv1[31:16], uv0[31:16]);
            du2_reg <= sub16(uv2[15:0],  uv0[15:0]);
            dv2_reg <= sub16(uv2[31:16], uv0[31:16]);

            // stage 2: products
            sd_reg[1] <= sd_reg[0];
            for (int k = 0; k < 3; k++) begin
                pa_reg[k] <= dv2_reg * e1_reg[k];
                pb_reg[k] <= dv1_reg * e2_reg[k];
            end
            pd1_reg <= du1_reg * dv2_reg;
            pd2_reg <= du2_reg * dv1_reg;

            // stage 3: tangent and determinant
            sd_reg[2] <= sd2_next;
            for (int k = 0; k < 3; k++) begin
                t_reg[k] <= T_W'(pa_reg[k]) - T_W'(pb_reg[k]);
            end
            det_neg_reg  <= det_next[T_W-1];
            det_zero_reg <= (det_next == '0);

            // stage 4: magnitudes and signs
            sd_reg[3] <= sd3_next;
            for (int k = 0; k < 3; k++) begin
                mag_reg[k] <= abs_next[k];
            end
            max_reg <= max_next;

            // stage 5: leading one
            sd_reg[4] <= sd_reg[3];
            mag5_reg  <= mag_reg;
            top_reg   <= top_next;

            // stage 6: normalizing shift
            sd_reg[5] <= sd_reg[4];
            for (int k = 0; k < 3; k++) begin
                if (top_reg < NRM_TOP) begin
                    nrm_reg[k] <= NRM_W'(mag5_reg[k] << (NRM_TOP - top_reg));
                end else begin
                    nrm_reg[k] <= NRM_W'(mag5_reg[k] >> (top_reg - NRM_TOP));
                end
            end

            // stage 7: squares
            sd_reg[6] <= sd_reg[5];
            nrm7_reg  <= nrm_reg;
            for (int k = 0; k < 3; k++) begin
                sq_reg[k] <= SQ_W'(nrm_reg[k]) * SQ_W'(nrm_reg[k]);
            end

            // stage 8: sum
            sd_reg[7] <= sd_reg[6];
            nrm8_reg  <= nrm7_reg;
            sum_reg   <= SUM_W'(sq_reg[0]) + SUM_W'(sq_reg[1]) + SUM_W'(sq_reg[2]);
        end
    end

    assign out_valid = vld_reg[FRONT_STAGES-1];
    assign out_side  = sd_reg[FRONT_STAGES-1];
    assign out_mag   = nrm8_reg;
    assign out_sum   = sum_reg;

endmodule

// ----- hdl/tgc_sqrt.sv -----
// Pipelined integer square root, one root bit per stage.
// Depends on tgc_pkg.
module tgc_sqrt
    import tgc_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              en,
    input  logic              in_valid,
    input  side_t             in_side,
    input  nrm3_t             in_mag,
    input  logic [SUM_W-1:0]  in_sum,
    output logic              out_valid,
    output side_t             out_side,
    output nrm3_t             out_mag,
    output logic [ROOT_W-1:0] out_root
);

    logic [ROOT_W-1:0] vld_reg;
    side_t             sd_reg   [ROOT_W];
    nrm3_t             mag_reg  [ROOT_W];
    logic [SUM_W-1:0]  n_reg    [ROOT_W];
    logic [REM_W-1:0]  rem_reg  [ROOT_W];
    logic [ROOT_W-1:0] root_reg [ROOT_W];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (en) begin
            vld_reg <= {vld_reg[ROOT_W-2:0], in_valid};
        end
    end

    for (genvar g = 0; g < ROOT_W; g++) begin : g_step
        side_t             sd_prev;
        nrm3_t             mag_prev;
        logic [SUM_W-1:0]  n_prev;
        logic [REM_W-1:0]  rem_prev;
        logic [ROOT_W-1:0] root_prev;
        logic [REM_W-1:0]  rem_sh;
        logic [REM_W-1:0]  trial;

        if (g == 0) begin : g_first
            assign sd_prev   = in_side;
            assign mag_prev  = in_mag;
            assign n_prev    = in_sum;
            assign rem_prev  = '0;
            assign root_prev = '0;
        end else begin : g_rest
            assign sd_prev   = sd_reg[g-1];
            assign mag_prev  = mag_reg[g-1];
            assign n_prev    = n_reg[g-1];
            assign rem_prev  = rem_reg[g-1];
            assign root_prev = root_reg[g-1];
        end

        assign rem_sh = {rem_prev[REM_W-3:0], n_prev[2*(ROOT_W-1-g) +: 2]};
        assign trial  = REM_W'({root_prev, 2'b01});

        always_ff @(posedge aclk) begin
            if (en) begin
                sd_reg[g]  <= sd_prev;
                mag_reg[g] <= mag_prev;
                n_reg[g]   <= n_prev;
                if (rem_sh >= trial) begin
                    rem_reg[g]  <= rem_sh - trial;
                    root_reg[g] <= {root_prev[ROOT_W-2:0], 1'b1};
                end else begin
                    rem_reg[g]  <= rem_sh;
                    root_reg[g] <= {root_prev[ROOT_W-2:0], 1'b0};
                end
            end
        end
    end

    assign out_valid = vld_reg[ROOT_W-1];
    assign out_side  = sd_reg[ROOT_W-1];
    assign out_mag   = mag_reg[ROOT_W-1];
    assign out_root  = root_reg[ROOT_W-1];

endmodule

// ----- hdl/tgc_div.sv -----
// Pipelined restoring divider, three lanes, one quotient bit per stage,
// rounding term added in a first stage. Depends on tgc_pkg.
module tgc_div
    import tgc_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              en,
    input  logic              in_valid,
    input  side_t             in_side,
    input  nrm3_t             in_mag,
    input  logic [ROOT_W-1:0] in_len,
    output logic              out_valid,
    output side_t             out_side,
    output logic [2:0][QUO_W-1:0] out_quo
);

    logic                      vld0_reg;
    side_t                     sd0_reg;
    logic [ROOT_W-1:0]         len0_reg;
    logic [2:0][NUM_W-1:0]     num0_reg;

    logic [QUO_W-1:0]          vld_reg;
    side_t                     sd_reg  [QUO_W];
    logic [ROOT_W-1:0]         len_reg [QUO_W];
    logic [2:0][NUM_W-1:0]     rem_reg [QUO_W];
    logic [2:0][QUO_W-1:0]     quo_reg [QUO_W];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld0_reg <= 1'b0;
            vld_reg  <= '0;
        end else if (en) begin
            vld0_reg <= in_valid;
            vld_reg  <= {vld_reg[QUO_W-2:0], vld0_reg};
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            sd0_reg  <= in_side;
            len0_reg <= in_len;
            for (int k = 0; k < 3; k++) begin
                num0_reg[k] <= NUM_W'({in_mag[k], 14'b0}) + NUM_W'(in_len >> 1);
            end
        end
    end

    for (genvar g = 0; g < QUO_W; g++) begin : g_step
        side_t                 sd_prev;
        logic [ROOT_W-1:0]     len_prev;
        logic [2:0][NUM_W-1:0] rem_prev;
        logic [2:0][QUO_W-1:0] quo_prev;
        logic [NUM_W-1:0]      dsr;

        if (g == 0) begin : g_first
            assign sd_prev  = sd0_reg;
            assign len_prev = len0_reg;
            assign rem_prev = num0_reg;
            assign quo_prev = '0;
        end else begin : g_rest
            assign sd_prev  = sd_reg[g-1];
            assign len_prev = len_reg[g-1];
            assign rem_prev = rem_reg[g-1];
            assign quo_prev = quo_reg[g-1];
        end

        assign dsr = NUM_W'(len_prev) << (QUO_W - 1 - g);

        always_ff @(posedge aclk) begin
            if (en) begin
                sd_reg[g]  <= sd_prev;
                len_reg[g] <= len_prev;
                for (int k = 0; k < 3; k++) begin
                    if (rem_prev[k] >= dsr) begin
                        rem_reg[g][k] <= rem_prev[k] - dsr;
                        quo_reg[g][k] <= {quo_prev[k][QUO_W-2:0], 1'b1};
                    end else begin
                        rem_reg[g][k] <= rem_prev[k];
                        quo_reg[g][k] <= {quo_prev[k][QUO_W-2:0], 1'b0};
                    end
                end
            end
        end
    end

    assign out_valid = vld_reg[QUO_W-1];
    assign out_side  = sd_reg[QUO_W-1];
    assign out_quo   = quo_reg[QUO_W-1];

endmodule

// ----- hdl/triangle_tangent_compute.sv -----
// Triangle tangent unit: top level, stream ports and output register.
// Depends on tgc_pkg, tgc_front, tgc_sqrt, tgc_div.
// Pipeline: front, root and divide stages, then an output register.
// Throughput: one triangle per cycle; the whole pipeline holds while the result waits.
// Reset: synchronous active-low aresetn clears all valid bits; payload is not reset.
module triangle_tangent_compute
    import tgc_pkg::*;
(
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    // corner_a_index, corner_b_index, corner_c_index, first_position,
    // second_position, third_position, first_texcoord, second_texcoord,
    // third_texcoord
    input  logic [287:0] s_tdata,
    output logic         m_tvalid,
    input  logic         m_tready,
    // out_index_a, out_index_b, out_index_c, tangent_x, tangent_y, tangent_z,
    // handedness_negative, zero pad
    output logic [103:0] m_tdata,
    // degenerate
    output logic         m_tuser
);

    logic en;

    logic  f_valid;
    side_t f_side;
    nrm3_t f_mag;
    logic [SUM_W-1:0] f_sum;

    logic  r_valid;
    side_t r_side;
    nrm3_t r_mag;
    logic [ROOT_W-1:0] r_root;

    logic  d_valid;
    side_t d_side;
    logic [2:0][QUO_W-1:0] d_quo;

    logic                   m_valid_reg;
    side_t                  m_side_reg;
    logic [2:0][OUT_W-1:0]  m_tan_reg;
    logic [2:0][OUT_W-1:0]  tan_next;

    assign en       = !m_valid_reg || m_tready;
    assign s_tready = en;

    tgc_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (s_tvalid),
        .idx_a     (s_tdata[15:0]),
        .idx_b     (s_tdata[31:16]),
        .idx_c     (s_tdata[47:32]),
        .pos0      (s_tdata[95:48]),
        .pos1      (s_tdata[143:96]),
        .pos2      (s_tdata[191:144]),
        .uv0       (s_tdata[223:192]),
        .uv1       (s_tdata[255:224]),
        .uv2       (s_tdata[287:256]),
        .out_valid (f_valid),
        .out_side  (f_side),
        .out_mag   (f_mag),
        .out_sum   (f_sum)
    );

    tgc_sqrt u_sqrt (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (f_valid),
        .in_side   (f_side),
        .in_mag    (f_mag),
        .in_sum    (f_sum),
        .out_valid (r_valid),
        .out_side  (r_side),
        .out_mag   (r_mag),
        .out_root  (r_root)
    );

    tgc_div u_div (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (r_valid),
        .in_side   (r_side),
        .in_mag    (r_mag),
        .in_len    (r_root),
        .out_valid (d_valid),
        .out_side  (d_side),
        .out_quo   (d_quo)
    );

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            logic [QUO_W-1:0] q;
            q = (d_quo[k] > Q_ONE) ? Q_ONE : d_quo[k];
            if (d_side.degen) begin
                tan_next[k] = '0;
            end else if (d_side.neg[k]) begin
                tan_next[k] = -OUT_W'(q);
            end else begin
                tan_next[k] = OUT_W'(q);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (en) begin
            m_valid_reg <= d_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            m_side_reg <= d_side;
            m_tan_reg  <= tan_next;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tuser  = m_side_reg.degen;
    assign m_tdata  = {7'b0, m_side_reg.hand_neg, m_tan_reg[2], m_tan_reg[1], m_tan_reg[0],
                       m_side_reg.idx_c, m_side_reg.idx_b, m_side_reg.idx_a};

endmodule

// ----- hdl/tgc_checker.sv -----
// Port-level checks for the triangle tangent unit, bound to the top level.
// Depends on triangle_tangent_compute's port list.
module tgc_checker (
    input logic         aclk,
    input logic         aresetn,
    input logic         s_tvalid,
    input logic         s_tready,
    input logic [287:0] s_tdata,
    input logic         m_tvalid,
    input logic         m_tready,
    input logic [103:0] m_tdata,
    input logic         m_tuser
);

    a_reset_clears: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

    a_ready_when_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_tvalid |-> s_tready)
        else $error("input stalled with empty output");

    a_degen_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser) |-> (m_tdata[95:48] == 48'd0))
        else $error("degenerate result with nonzero tangent");

    a_unit_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> ($signed(m_tdata[63:48]) <= 16'sd16384
                   && $signed(m_tdata[63:48]) >= -16'sd16384
                   && $signed(m_tdata[79:64]) <= 16'sd16384
                   && $signed(m_tdata[79:64]) >= -16'sd16384
                   && $signed(m_tdata[95:80]) <= 16'sd16384
                   && $signed(m_tdata[95:80]) >= -16'sd16384))
        else $error("tangent component out of range");

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata) && $stable(m_tuser)))
        else $error("stalled result changed");

endmodule

bind triangle_tangent_compute tgc_checker u_tgc_checker (.*);

// ----- bench/testbench.sv -----
// Testbench for triangle_tangent_compute: random and directed triangles,
// results checked against an in-bench fixed-point tangent predictor.
// Depends on tgc_pkg and triangle_tangent_compute.
module testbench;
    import tgc_pkg::*;

    typedef struct {
        logic [287:0] data;
    } tri_req_t;

    typedef struct {
        logic [103:0] data;
        logic         degen;
    } tangent_res_t;

    logic         aclk;
    logic         aresetn;
    logic         s_tvalid;
    logic         s_tready;
    logic [287:0] s_tdata;
    logic         m_tvalid;
    logic         m_tready;
    logic [103:0] m_tdata;
    logic         m_tuser;

    tri_req_t     pending_tris[$];
    tangent_res_t expected_tangents[$];
    int           mismatches;
    bit           calm;
    int           hold_left;
    bit           sender_pause;
    bit           in_fire;

    triangle_tangent_compute u_dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .m_tuser(m_tuser)
    );

    initial begin
        aclk = 1'b0;
        forever #6 aclk = ~aclk;
    end

    function automatic longint lane(logic [287:0] d, int base);
        return longint'($signed(d[base +: 16]));
    endfunction

    function automatic longint unsigned int_sqrt(longint unsigned n);
        longint unsigned root;
        longint unsigned bitv;
        root = 0;
        bitv = 64'd1 << 62;
        while (bitv > n) bitv >>= 2;
        while (bitv != 0) begin
            if (n >= root + bitv) begin
                n -= root + bitv;
                root = (root >> 1) + bitv;
            end else begin
                root >>= 1;
            end
            bitv >>= 2;
        end
        return root;
    endfunction

    function automatic tangent_res_t predict_tangent(logic [287:0] d);
        tangent_res_t     r;
        longint           e1[3], e2[3], t[3];
        longint unsigned  mg[3], m, sum, len, q;
        longint           du1, dv1, du2, dv2, det;
        int               top;
        bit               flip, neg;
        logic [15:0]      comp[3];
        for (int k = 0; k < 3; k++) begin
            e1[k] = lane(d, 96 + 16*k) - lane(d, 48 + 16*k);
            e2[k] = lane(d, 144 + 16*k) - lane(d, 48 + 16*k);
        end
        du1 = lane(d, 224) - lane(d, 192);
        dv1 = lane(d, 240) - lane(d, 208);
        du2 = lane(d, 256) - lane(d, 192);
        dv2 = lane(d, 272) - lane(d, 208);
        det = du1 * dv2 - du2 * dv1;
        for (int k = 0; k < 3; k++) t[k] = dv2 * e1[k] - dv1 * e2[k];
        r.degen = (det == 0) || (t[0] == 0 && t[1] == 0 && t[2] == 0);
        comp = '{16'd0, 16'd0, 16'd0};
        if (!r.degen) begin
            flip = det < 0;
            m = 0;
            for (int k = 0; k < 3; k++) begin
                mg[k] = t[k] < 0 ? longint'(-t[k]) : longint'(t[k]);
                if (mg[k] > m) m = mg[k];
            end
            top = 0;
            while (top < 63 && (m >> (top + 1)) != 0) top++;
            for (int k = 0; k < 3; k++) begin
                if (top < 23) mg[k] <<= (23 - top);
                else if (top > 23) mg[k] >>= (top - 23);
            end
            sum = mg[0]*mg[0] + mg[1]*mg[1] + mg[2]*mg[2];
            len = int_sqrt(sum);
            if (len == 0) len = 1;
            for (int k = 0; k < 3; k++) begin
                q = (mg[k] * 16384 + (len >> 1)) / len;
                if (q > 16384) q = 16384;
                neg = (t[k] < 0) != flip;
                comp[k] = neg ? 16'(-q) : 16'(q);
            end
        end
        r.data = {7'd0, (det > 0) ? 1'b1 : 1'b0, comp[2], comp[1], comp[0], d[47:0]};
        return r;
    endfunction

    function automatic logic [15:0] rand_q();
        case ($urandom_range(0, 5))
            0: return 16'h7fff;
            1: return 16'h8000;
            2: return 16'(($urandom_range(0, 64)) - 32);
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic logic [287:0] rand_tri();
        logic [287:0] d;
        for (int k = 0; k < 18; k++) d[16*k +: 16] = (k < 3) ? 16'($urandom) : rand_q();
        if ($urandom_range(0, 9) == 0) d[287:256] = d[255:224];     // collinear uv
        if ($urandom_range(0, 9) == 0) d[191:96] = {d[95:48], d[95:48]}; // flat positions
        return d;
    endfunction

    task automatic queue_tri(logic [287:0] d);
        tri_req_t q;
        q.data = d;
        pending_tris.push_back(q);
    endtask

    // driver
    always @(negedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else begin
            if (in_fire) void'(pending_tris.pop_front());
            if (pending_tris.size() != 0 && !sender_pause
                && (calm || $urandom_range(0, 99) >= 28)) begin
                s_tvalid <= 1'b1;
                s_tdata  <= pending_tris[0].data;
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // predictor on accepted requests
    always @(posedge aclk) begin
        in_fire = aresetn && s_tvalid && s_tready;
        if (in_fire)
            expected_tangents.push_back(predict_tangent(s_tdata));
    end

    // receiver ready
    always @(negedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            m_tready  <= 1'b0;
        end else begin
            m_tready <= calm || $urandom_range(0, 99) >= 28;
        end
    end

    // monitor
    always @(posedge aclk) begin
        tangent_res_t exp_r;
        if (aresetn && m_tvalid && m_tready) begin
            if (expected_tangents.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected result %h", m_tdata);
            end else begin
                exp_r = expected_tangents.pop_front();
                if (exp_r.data !== m_tdata || exp_r.degen !== m_tuser) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: exp %h/%b got %h/%b",
                                 exp_r.data, exp_r.degen, m_tdata, m_tuser);
                end
            end
        end
    end

    initial begin
        #20000000;
        $display("testbench: done, errors");
        $finish;
    end

    initial begin
        logic [287:0] d;
        int waited;
        aresetn = 1'b0; s_tvalid = 1'b0; s_tdata = '0; m_tready = 1'b0;
        mismatches = 0; calm = 1'b0; hold_left = 0; sender_pause = 1'b0;
        repeat (11) @(posedge aclk);
        @(negedge aclk) aresetn = 1'b1;

        // directed: extremes, degenerate and both handedness signs
        queue_tri('0);
        queue_tri('1);
        d = '0; d[47:0] = {16'hffff, 16'h0000, 16'hffff};
        d[111:96] = 16'h0100; d[175:160] = 16'h0100;
        d[239:224] = 16'h1000; d[287:272] = 16'h1000;
        queue_tri(d);
        d[239:224] = 16'h0000; d[255:240] = 16'h1000; d[287:272] = 16'h0000;
        d[271:256] = 16'h1000;
        queue_tri(d);
        d = '0;
        for (int k = 3; k < 18; k++) d[16*k +: 16] = (k % 2) ? 16'h7fff : 16'h8000;
        queue_tri(d);
        d = '0;
        for (int k = 3; k < 18; k++) d[16*k +: 16] = (k % 2) ? 16'h8000 : 16'h7fff;
        queue_tri(d);
        d = '0; d[255:240] = 16'h1000; d[271:256] = 16'h1000;   // D nonzero, T zero
        queue_tri(d);
        for (int i = 0; i < 10; i++) queue_tri(rand_tri());
        wait (pending_tris.size() == 0);

        // back pressure: receiver holds off while sender streams
        for (int i = 0; i < 150; i++) queue_tri(rand_tri());
        @(negedge aclk) hold_left = 200;
        wait (pending_tris.size() == 0);

        // sender pause until drained
        sender_pause = 1'b1;
        wait (expected_tangents.size() == 0);
        sender_pause = 1'b0;

        // no-idle stretch
        calm = 1'b1;
        for (int i = 0; i < 300; i++) queue_tri(rand_tri());
        wait (pending_tris.size() == 0);
        calm = 1'b0;

        for (int i = 0; i < 730; i++) queue_tri(rand_tri());
        wait (pending_tris.size() == 0);
        @(posedge aclk);
        waited = 0;
        while (expected_tangents.size() != 0 && waited < 20000) begin
            @(posedge aclk);
            waited++;
        end
        repeat (60) @(posedge aclk);
        if (mismatches == 0 && expected_tangents.size() == 0)
            $display("testbench: done, clean");
        else
            $display("testbench: done, errors");
        $finish;
    end
endmodule
